// ===== design/mfdu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfdu_pkg
// Shared types, codes and the identifier decode for the motor feedback
// decoder with multi-turn angle unwrap.
// ----------------------------------------------------------------------------
package mfdu_pkg;

	localparam logic OP_FRAME  = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	localparam logic [1:0] CFG_JUMP_THRESHOLD  = 2'd0;
	localparam logic [1:0] CFG_CENTER_OFFSET   = 2'd1;
	localparam logic [1:0] CFG_COUNTS_PER_TURN = 2'd2;

	localparam logic [15:0] RST_JUMP_THRESHOLD  = 16'd4096;
	localparam logic [15:0] RST_CENTER_OFFSET   = 16'd0;
	localparam logic [15:0] RST_COUNTS_PER_TURN = 16'd8192;

	localparam logic [10:0] ID_CHASSIS_0 = 11'h201;
	localparam logic [10:0] ID_CHASSIS_1 = 11'h202;
	localparam logic [10:0] ID_CHASSIS_2 = 11'h208;
	localparam logic [10:0] ID_CHASSIS_3 = 11'h207;
	localparam logic [10:0] ID_CHASSIS_4 = 11'h203;
	localparam logic [10:0] ID_CHASSIS_5 = 11'h204;
	localparam logic [10:0] ID_GIMBAL_0  = 11'h209;
	localparam logic [10:0] ID_GIMBAL_1  = 11'h20a;

	typedef struct packed {
		logic       hit;
		logic       gim;
		logic [2:0] slot;
	} id_map_t;

	typedef struct packed {
		logic        op;
		logic        known;
		logic        grp;
		logic [2:0]  slot;
		logic [15:0] angle;
		logic [15:0] speed;
		logic [15:0] current;
		logic [7:0]  temp;
	} cmd_t;

	function automatic id_map_t decode_id(input logic [10:0] id);
		id_map_t m;
		m = '0;
		case (id)
			ID_CHASSIS_0: m = '{hit: 1'b1, gim: 1'b0, slot: 3'd0};
			ID_CHASSIS_1: m = '{hit: 1'b1, gim: 1'b0, slot: 3'd1};
			ID_CHASSIS_2: m = '{hit: 1'b1, gim: 1'b0, slot: 3'd2};
			ID_CHASSIS_3: m = '{hit: 1'b1, gim: 1'b0, slot: 3'd3};
			ID_CHASSIS_4: m = '{hit: 1'b1, gim: 1'b0, slot: 3'd4};
			ID_CHASSIS_5: m = '{hit: 1'b1, gim: 1'b0, slot: 3'd5};
			ID_GIMBAL_0:  m = '{hit: 1'b1, gim: 1'b1, slot: 3'd0};
			ID_GIMBAL_1:  m = '{hit: 1'b1, gim: 1'b1, slot: 3'd1};
			default:      m = '0;
		endcase
		return m;
	endfunction

endpackage

// ===== design/motor_feedback_decode_unwrap_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_decode_unwrap_core
// Motor feedback decoder with multi-turn angle unwrap: front classifier and
// command queue, back executor with slot state and output register.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    op, can_id, byte_zero..six, motor_index
// out      output     out_valid / out_ready  known_id, group, slot, angle_delta,
//                                            turn_count, long_angle
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each item goes through the back in order: state read and update, the
// counts-per-turn multiply, and the long-angle sum into the output register.
// The back executes one item at a time; the two-entry queue takes up to two
// more items while it works. in_ready drops only when the queue is full.
// Reset clears all slot state and restores the register defaults at once.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module motor_feedback_decode_unwrap_core #(
	parameter int CHASSIS_SLOTS = 8,
	parameter int GIMBAL_SLOTS  = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [10:0]        can_id,
	input  logic [7:0]         byte_zero,
	input  logic [7:0]         byte_one,
	input  logic [7:0]         byte_two,
	input  logic [7:0]         byte_three,
	input  logic [7:0]         byte_four,
	input  logic [7:0]         byte_five,
	input  logic [7:0]         byte_six,
	input  logic [2:0]         motor_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               known_id,
	output logic               group,
	output logic [2:0]         slot,
	output logic signed [16:0] angle_delta,
	output logic signed [31:0] turn_count,
	output logic signed [47:0] long_angle,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	logic           q_valid;
	logic           q_pop;
	mfdu_pkg::cmd_t q_cmd;

	mfdu_front #(
		.CHASSIS_SLOTS(CHASSIS_SLOTS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.can_id      (can_id),
		.byte_zero   (byte_zero),
		.byte_one    (byte_one),
		.byte_two    (byte_two),
		.byte_three  (byte_three),
		.byte_four   (byte_four),
		.byte_five   (byte_five),
		.byte_six    (byte_six),
		.motor_index (motor_index),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_cmd       (q_cmd)
	);

	mfdu_back #(
		.CHASSIS_SLOTS(CHASSIS_SLOTS),
		.GIMBAL_SLOTS (GIMBAL_SLOTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_cmd       (q_cmd),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.known_id    (known_id),
		.group       (group),
		.slot        (slot),
		.angle_delta (angle_delta),
		.turn_count  (turn_count),
		.long_angle  (long_angle)
	);

endmodule

// ===== design/mfdu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfdu_front
// Accepts input items, classifies them (identifier decode, slot range check)
// and queues the resulting commands in a two-entry FIFO.
// ----------------------------------------------------------------------------
module mfdu_front #(
	parameter int CHASSIS_SLOTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                op,
	input  logic [10:0]         can_id,
	input  logic [7:0]          byte_zero,
	input  logic [7:0]          byte_one,
	input  logic [7:0]          byte_two,
	input  logic [7:0]          byte_three,
	input  logic [7:0]          byte_four,
	input  logic [7:0]          byte_five,
	input  logic [7:0]          byte_six,
	input  logic [2:0]          motor_index,
	output logic                q_valid,
	input  logic                q_pop,
	output mfdu_pkg::cmd_t      q_cmd
);

	mfdu_pkg::cmd_t    fifo_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;
	mfdu_pkg::id_map_t map;
	mfdu_pkg::cmd_t    cmd;

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_cmd    = fifo_q[rd_ptr_q];

	always_comb begin
		map         = mfdu_pkg::decode_id(can_id);
		cmd.op      = op;
		cmd.angle   = {byte_zero, byte_one};
		cmd.speed   = {byte_two, byte_three};
		cmd.current = {byte_four, byte_five};
		cmd.temp    = byte_six;
		if (op == mfdu_pkg::OP_UPDATE) begin
			cmd.known = ({29'd0, motor_index} < 32'(CHASSIS_SLOTS));
			cmd.grp   = 1'b0;
			cmd.slot  = motor_index;
		end else begin
			cmd.known = map.hit;
			cmd.grp   = map.gim;
			cmd.slot  = map.slot;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> count_q != 2'd0)
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2 && !q_pop) |=> count_q == 2'd2)
		else $error("full queue lost an entry");

endmodule

// ===== design/mfdu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfdu_back
// Executes queued commands: stores feedback frames, unwraps chassis angles
// into a turn count and long angle, and holds the configuration registers
// and the output register.
// ----------------------------------------------------------------------------
module mfdu_back #(
	parameter int CHASSIS_SLOTS = 8,
	parameter int GIMBAL_SLOTS  = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                q_valid,
	output logic                q_pop,
	input  mfdu_pkg::cmd_t      q_cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                known_id,
	output logic                group,
	output logic [2:0]          slot,
	output logic signed [16:0]  angle_delta,
	output logic signed [31:0]  turn_count,
	output logic signed [47:0]  long_angle
);

	localparam int CIW = $clog2(CHASSIS_SLOTS);
	localparam int GIW = $clog2(GIMBAL_SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL  = 3'b010,
		ST_FIN  = 3'b100
	} st_t;

	st_t st_q;

	logic [15:0] jump_q;
	logic [15:0] center_q;
	logic [15:0] cpt_q;

	logic [15:0] chassis_angle_q   [CHASSIS_SLOTS];
	logic [15:0] chassis_speed_q   [CHASSIS_SLOTS];
	logic [15:0] chassis_current_q [CHASSIS_SLOTS];
	logic [7:0]  chassis_temp_q    [CHASSIS_SLOTS];
	logic [15:0] gimbal_angle_q    [GIMBAL_SLOTS];
	logic [15:0] gimbal_speed_q    [GIMBAL_SLOTS];
	logic [15:0] gimbal_current_q  [GIMBAL_SLOTS];
	logic [7:0]  gimbal_temp_q     [GIMBAL_SLOTS];
	logic [15:0] prev_angle_q      [CHASSIS_SLOTS];
	logic [31:0] turns_q           [CHASSIS_SLOTS];

	logic [CIW-1:0]     cidx;
	logic [GIW-1:0]     gidx;
	logic               is_upd;
	logic               wr_chassis;
	logic               wr_gimbal;
	logic signed [15:0] now_ang;
	logic signed [15:0] prev_ang;
	logic signed [17:0] delta_x;
	logic signed [17:0] jump_x;
	logic [31:0]        turns_cur;
	logic [31:0]        turns_nxt;
	logic               out_free;

	logic               known_s1;
	logic               grp_s1;
	logic [2:0]         slot_s1;
	logic               upd_s1;
	logic signed [16:0] delta_s1;
	logic signed [31:0] turns_s1;
	logic signed [15:0] now_s1;
	logic signed [47:0] prod_s2;
	logic signed [47:0] cpt_x;
	logic signed [47:0] turns_x;
	logic signed [47:0] long_nxt;

	assign cfg_ready = 1'b1;
	assign q_pop     = (st_q == ST_IDLE) && q_valid;
	assign out_free  = !out_valid || out_ready;

	assign cidx       = CIW'(q_cmd.slot);
	assign gidx       = GIW'(q_cmd.slot);
	assign is_upd     = q_pop && (q_cmd.op == mfdu_pkg::OP_UPDATE) && q_cmd.known;
	assign wr_chassis = q_pop && (q_cmd.op == mfdu_pkg::OP_FRAME) && q_cmd.known
	                    && !q_cmd.grp;
	assign wr_gimbal  = q_pop && (q_cmd.op == mfdu_pkg::OP_FRAME) && q_cmd.known
	                    && q_cmd.grp;

	always_comb begin
		now_ang   = '0;
		prev_ang  = '0;
		turns_cur = '0;
		if (is_upd) begin
			now_ang   = chassis_angle_q[cidx];
			prev_ang  = prev_angle_q[cidx];
			turns_cur = turns_q[cidx];
		end
		delta_x = 18'(now_ang) - 18'(prev_ang);
		jump_x  = signed'({2'b00, jump_q});
		if (delta_x < -jump_x) begin
			turns_nxt = turns_cur + 32'd1;
		end else if (delta_x > jump_x) begin
			turns_nxt = turns_cur - 32'd1;
		end else begin
			turns_nxt = turns_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_q   <= mfdu_pkg::RST_JUMP_THRESHOLD;
			center_q <= mfdu_pkg::RST_CENTER_OFFSET;
			cpt_q    <= mfdu_pkg::RST_COUNTS_PER_TURN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mfdu_pkg::CFG_JUMP_THRESHOLD:  jump_q   <= cfg_data;
				mfdu_pkg::CFG_CENTER_OFFSET:   center_q <= cfg_data;
				mfdu_pkg::CFG_COUNTS_PER_TURN: cpt_q    <= cfg_data;
				default:                       jump_q   <= jump_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHASSIS_SLOTS; i++) begin
				chassis_angle_q[i]   <= '0;
				chassis_speed_q[i]   <= '0;
				chassis_current_q[i] <= '0;
				chassis_temp_q[i]    <= '0;
				prev_angle_q[i]      <= '0;
				turns_q[i]           <= '0;
			end
			for (int i = 0; i < GIMBAL_SLOTS; i++) begin
				gimbal_angle_q[i]   <= '0;
				gimbal_speed_q[i]   <= '0;
				gimbal_current_q[i] <= '0;
				gimbal_temp_q[i]    <= '0;
			end
		end else begin
			if (wr_chassis) begin
				chassis_angle_q[cidx]   <= q_cmd.angle;
				chassis_speed_q[cidx]   <= q_cmd.speed;
				chassis_current_q[cidx] <= q_cmd.current;
				chassis_temp_q[cidx]    <= q_cmd.temp;
			end
			if (wr_gimbal) begin
				gimbal_angle_q[gidx]   <= q_cmd.angle;
				gimbal_speed_q[gidx]   <= q_cmd.speed;
				gimbal_current_q[gidx] <= q_cmd.current;
				gimbal_temp_q[gidx]    <= q_cmd.temp;
			end
			if (is_upd) begin
				prev_angle_q[cidx] <= chassis_angle_q[cidx];
				turns_q[cidx]      <= turns_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			known_s1 <= q_cmd.known;
			grp_s1   <= q_cmd.grp;
			slot_s1  <= q_cmd.slot;
			upd_s1   <= is_upd;
			delta_s1 <= is_upd ? delta_x[16:0] : 17'sd0;
			turns_s1 <= is_upd ? signed'(turns_nxt) : 32'sd0;
			now_s1   <= now_ang;
		end
	end

	assign cpt_x   = signed'({32'd0, cpt_q});
	assign turns_x = 48'(turns_s1);

	always_ff @(posedge clk) begin
		if (st_q == ST_MUL) begin
			prod_s2 <= cpt_x * turns_x;
		end
	end

	assign long_nxt = upd_s1 ? (48'(signed'(center_q)) - 48'(now_s1) - prod_s2) : 48'sd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (q_pop) begin
						st_q <= ST_MUL;
					end
				end
				ST_MUL: st_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (st_q == ST_FIN && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_FIN && out_free) begin
			known_id    <= known_s1;
			group       <= grp_s1;
			slot        <= slot_s1;
			angle_delta <= delta_s1;
			turn_count  <= turns_s1;
			long_angle  <= long_nxt;
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> st_q == ST_MUL)
		else $error("pop did not start execution");

	a_mul_fin: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_MUL |=> st_q == ST_FIN)
		else $error("multiply stage did not advance");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FIN && !out_free) |=> st_q == ST_FIN)
		else $error("result dropped while output busy");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !known_id) |-> (angle_delta == 17'sd0 && turn_count == 32'sd0
			&& long_angle == 48'sd0))
		else $error("nonzero fields on unknown result");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the motor feedback decoder with multi-turn unwrap.
// A short directed table covers the identifier map, unknown identifiers, byte
// extremes and the threshold edges. Random traffic follows: chassis angles
// take slow walks with wraps, updates come between them, and noise frames are
// mixed in. This runs under several register settings and idle patterns. Each
// transfer out is compared field by field with an in-order prediction.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct packed {
		logic        op;
		logic [10:0] can_id;
		logic [15:0] angle;
		logic [15:0] speed;
		logic [15:0] current;
		logic [7:0]  temp;
		logic [2:0]  motor_index;
	} feedback_item_t;

	typedef struct packed {
		logic               known;
		logic               grp;
		logic [2:0]         slot;
		logic signed [16:0] delta;
		logic signed [31:0] turns;
		logic signed [47:0] long_angle;
	} decoded_result_t;

	typedef struct packed {
		feedback_item_t item;
		logic           typed;
		logic           known;
		logic           grp;
		logic [2:0]     slot;
	} directed_row_t;

	localparam int PHASES         = 7;
	localparam int ITEMS_PER_PHASE = 260;

	localparam logic [10:0] CHASSIS_IDS [6] = '{mfdu_pkg::ID_CHASSIS_0,
		mfdu_pkg::ID_CHASSIS_1, mfdu_pkg::ID_CHASSIS_2, mfdu_pkg::ID_CHASSIS_3,
		mfdu_pkg::ID_CHASSIS_4, mfdu_pkg::ID_CHASSIS_5};
	localparam logic [10:0] GIMBAL_IDS [2] = '{mfdu_pkg::ID_GIMBAL_0, mfdu_pkg::ID_GIMBAL_1};
	localparam logic [1:0] REG_ORDER [3] = '{mfdu_pkg::CFG_JUMP_THRESHOLD,
		mfdu_pkg::CFG_CENTER_OFFSET, mfdu_pkg::CFG_COUNTS_PER_TURN};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               op;
	logic [10:0]        can_id;
	logic [7:0]         byte_zero;
	logic [7:0]         byte_one;
	logic [7:0]         byte_two;
	logic [7:0]         byte_three;
	logic [7:0]         byte_four;
	logic [7:0]         byte_five;
	logic [7:0]         byte_six;
	logic [2:0]         motor_index;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               known_id;
	logic               group;
	logic [2:0]         slot;
	logic signed [16:0] angle_delta;
	logic signed [31:0] turn_count;
	logic signed [47:0] long_angle;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;

	logic [15:0] jump_limit;
	logic [15:0] center_ref;
	logic [15:0] counts_turn;
	logic [15:0] slot_angle [8];
	logic [15:0] last_angle [8];
	logic [31:0] turn_tally [8];

	logic [15:0] walk_angle [6];
	decoded_result_t pending_results [$];
	int mismatch_count;
	int send_idle_pct;
	int recv_idle_pct;

	directed_row_t directed_rows [25] = '{
		'{'{mfdu_pkg::OP_UPDATE, 11'h000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 3'd0},
			1'b1, 1'b1, 1'b0, 3'd0},
		'{'{mfdu_pkg::OP_FRAME, 11'h000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 3'd0},
			1'b1, 1'b0, 1'b0, 3'd0},
		'{'{mfdu_pkg::OP_FRAME, 11'h7ff, 16'hffff, 16'hffff, 16'hffff, 8'hff, 3'd7},
			1'b1, 1'b0, 1'b0, 3'd0},
		'{'{mfdu_pkg::OP_FRAME, mfdu_pkg::ID_CHASSIS_0, 16'h7fff, 16'h8000, 16'h7fff,
			8'hff, 3'd0}, 1'b1, 1'b1, 1'b0, 3'd0},
		'{'{mfdu_pkg::OP_FRAME, mfdu_pkg::ID_CHASSIS_1, 16'h8000, 16'h7fff, 16'h8000,
			8'h00, 3'd1}, 1'b1, 1'b1, 1'b0, 3'd1},
		'{'{mfdu_pkg::OP_FRAME, mfdu_pkg::ID_CHASSIS_2, 16'hffff, 16'hffff, 16'hffff,
			8'h80, 3'd2}, 1'b1, 1'b1, 1'b0, 3'd2},
		'{'{mfdu_pkg::OP_FRAME, mfdu_pkg::ID_CHASSIS_3, 16'h0000, 16'h0001, 16'hfffe,
			8'h7f, 3'd3}, 1'b1, 1'b1, 1'b0, 3'd3},
		'{'{mfdu_pkg::OP_FRAME, mfdu_pkg::ID_CHASSIS_4, 16'h1000, 16'h0100, 16'h0010,
			8'h01, 3'd4}, 1'b1, 1'b1, 1'b0, 3'd4},
		'{'{mfdu_pkg::OP_FRAME, mfdu_pkg::ID_CHASSIS_5, 16'hf000, 16'ha5a5, 16'h5a5a,
			8'h5a, 3'd5}, 1'b1, 1'b1, 1'b0, 3'd5},
		'{'{mfdu_pkg::OP_FRAME, mfdu_pkg::ID_GIMBAL_0, 16'h1234, 16'h8001, 16'h7ffe,
			8'hc3, 3'd6}, 1'b1, 1'b1, 1'b1, 3'd0},
		'{'{mfdu_pkg::OP_FRAME, mfdu_pkg::ID_GIMBAL_1, 16'h8000, 16'h0000, 16'hffff,
			8'h3c, 3'd7}, 1'b1, 1'b1, 1'b1, 3'd1},
		'{'{mfdu_pkg::OP_FRAME, 11'h200, 16'h4321, 16'h1111, 16'h2222, 8'h33, 3'd0},
			1'b1, 1'b0, 1'b0, 3'd0},
		'{'{mfdu_pkg::OP_FRAME, 11'h20b, 16'h5555, 16'haaaa, 16'h5555, 8'haa, 3'd1},
			1'b1, 1'b0, 1'b0, 3'd0},
		'{'{mfdu_pkg::OP_FRAME, 11'h205, 16'haaaa, 16'h5555, 16'haaaa, 8'h55, 3'd2},
			1'b1, 1'b0, 1'b0, 3'd0},
		'{'{mfdu_pkg::OP_UPDATE, 11'h7ff, 16'hffff, 16'hffff, 16'hffff, 8'hff, 3'd0},
			1'b0, 1'b0, 1'b0, 3'd0},
		'{'{mfdu_pkg::OP_UPDATE, 11'h000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 3'd1},
			1'b0, 1'b0, 1'b0, 3'd0},
		'{'{mfdu_pkg::OP_UPDATE, 11'h201, 16'h0000, 16'h0000, 16'h0000, 8'h00, 3'd2},
			1'b0, 1'b0, 1'b0, 3'd0},
		'{'{mfdu_pkg::OP_UPDATE, 11'h000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 3'd4},
			1'b0, 1'b0, 1'b0, 3'd0},
		'{'{mfdu_pkg::OP_UPDATE, 11'h000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 3'd5},
			1'b0, 1'b0, 1'b0, 3'd0},
		'{'{mfdu_pkg::OP_UPDATE, 11'h000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 3'd6},
			1'b0, 1'b0, 1'b0, 3'd0},
		'{'{mfdu_pkg::OP_UPDATE, 11'h000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 3'd7},
			1'b0, 1'b0, 1'b0, 3'd0},
		'{'{mfdu_pkg::OP_FRAME, mfdu_pkg::ID_CHASSIS_0, 16'h8000, 16'h0000, 16'h0000,
			8'h00, 3'd0}, 1'b1, 1'b1, 1'b0, 3'd0},
		'{'{mfdu_pkg::OP_UPDATE, 11'h000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 3'd0},
			1'b0, 1'b0, 1'b0, 3'd0},
		'{'{mfdu_pkg::OP_FRAME, mfdu_pkg::ID_CHASSIS_4, 16'hefff, 16'h0000, 16'h0000,
			8'h00, 3'd4}, 1'b1, 1'b1, 1'b0, 3'd4},
		'{'{mfdu_pkg::OP_UPDATE, 11'h000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 3'd4},
			1'b0, 1'b0, 1'b0, 3'd0}
	};

	motor_feedback_decode_unwrap_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.can_id     (can_id),
		.byte_zero  (byte_zero),
		.byte_one   (byte_one),
		.byte_two   (byte_two),
		.byte_three (byte_three),
		.byte_four  (byte_four),
		.byte_five  (byte_five),
		.byte_six   (byte_six),
		.motor_index(motor_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.known_id   (known_id),
		.group      (group),
		.slot       (slot),
		.angle_delta(angle_delta),
		.turn_count (turn_count),
		.long_angle (long_angle),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic decoded_result_t predict_feedback(input feedback_item_t it);
		decoded_result_t r;
		int          d;
		int          lim;
		int          n;
		longint      cpt;
		longint      t;
		longint      ctr;
		longint      now;
		longint      la;
		r = '0;
		if (it.op == mfdu_pkg::OP_FRAME) begin
			for (int k = 0; k < 6; k++) begin
				if (it.can_id == CHASSIS_IDS[k]) begin
					slot_angle[k] = it.angle;
					r.known = 1'b1;
					r.slot  = 3'(k);
				end
			end
			for (int k = 0; k < 2; k++) begin
				if (it.can_id == GIMBAL_IDS[k]) begin
					r.known = 1'b1;
					r.grp   = 1'b1;
					r.slot  = 3'(k);
				end
			end
		end else begin
			n   = it.motor_index;
			d   = $signed(slot_angle[n]) - $signed(last_angle[n]);
			lim = jump_limit;
			if (d < -lim)
				turn_tally[n] = turn_tally[n] + 32'd1;
			else if (d > lim)
				turn_tally[n] = turn_tally[n] - 32'd1;
			cpt = counts_turn;
			t   = $signed(turn_tally[n]);
			ctr = $signed(center_ref);
			now = $signed(slot_angle[n]);
			la  = -cpt * t + (ctr - now);
			last_angle[n] = slot_angle[n];
			r.known      = 1'b1;
			r.slot       = it.motor_index;
			r.delta      = d[16:0];
			r.turns      = turn_tally[n];
			r.long_angle = la[47:0];
		end
		return r;
	endfunction

	function automatic feedback_item_t random_item();
		feedback_item_t it;
		int pick;
		int k;
		int step;
		it.op          = mfdu_pkg::OP_FRAME;
		it.can_id      = 11'($urandom_range(2047));
		it.angle       = 16'($urandom);
		it.speed       = 16'($urandom);
		it.current     = 16'($urandom);
		it.temp        = 8'($urandom);
		it.motor_index = 3'($urandom_range(7));
		pick = $urandom_range(99);
		if (pick < 40) begin
			k = $urandom_range(5);
			if ($urandom_range(9) == 0) begin
				walk_angle[k] = 16'($urandom);
			end else begin
				step = int'($urandom_range(12000)) - 6000;
				walk_angle[k] = walk_angle[k] + step[15:0];
			end
			it.can_id = CHASSIS_IDS[k];
			it.angle  = walk_angle[k];
		end else if (pick < 75) begin
			it.op = mfdu_pkg::OP_UPDATE;
			if ($urandom_range(9) == 0)
				it.motor_index = 3'($urandom_range(7, 6));
			else
				it.motor_index = 3'($urandom_range(5));
		end else if (pick < 85) begin
			it.can_id = GIMBAL_IDS[$urandom_range(1)];
		end else begin
			it.op = 1'($urandom_range(1));
		end
		return it;
	endfunction

	task automatic report_mismatch(input string what, input logic [47:0] got,
		input logic [47:0] want);
		mismatch_count++;
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
	endtask

	task automatic send_item(input feedback_item_t it, input bit use_typed,
		input decoded_result_t typed_want);
		decoded_result_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= it.op;
		can_id      <= it.can_id;
		byte_zero   <= it.angle[15:8];
		byte_one    <= it.angle[7:0];
		byte_two    <= it.speed[15:8];
		byte_three  <= it.speed[7:0];
		byte_four   <= it.current[15:8];
		byte_five   <= it.current[7:0];
		byte_six    <= it.temp;
		motor_index <= it.motor_index;
		do @(posedge clk); while (!in_ready);
		want = predict_feedback(it);
		if (use_typed)
			want = typed_want;
		pending_results.push_back(want);
	endtask

	task automatic write_registers(input logic [15:0] vals [3]);
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= REG_ORDER[k];
			cfg_data  <= vals[k];
			do @(posedge clk); while (!cfg_ready);
			case (REG_ORDER[k])
				mfdu_pkg::CFG_JUMP_THRESHOLD:  jump_limit  = vals[k];
				mfdu_pkg::CFG_CENTER_OFFSET:   center_ref  = vals[k];
				mfdu_pkg::CFG_COUNTS_PER_TURN: counts_turn = vals[k];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_for_drain();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		decoded_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("transfer with nothing pending", long_angle, '0);
			end else begin
				want = pending_results.pop_front();
				if (known_id !== want.known)
					report_mismatch("known_id", known_id, want.known);
				if (group !== want.grp)
					report_mismatch("group", group, want.grp);
				if (slot !== want.slot)
					report_mismatch("slot", slot, want.slot);
				if (angle_delta !== want.delta)
					report_mismatch("angle_delta", angle_delta, want.delta);
				if (turn_count !== want.turns)
					report_mismatch("turn_count", turn_count, want.turns);
				if (long_angle !== want.long_angle)
					report_mismatch("long_angle", long_angle, want.long_angle);
			end
		end
	end

	initial begin
		logic [15:0] regs [3];
		directed_row_t row;
		int mode;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		op          <= mfdu_pkg::OP_FRAME;
		can_id      <= '0;
		byte_zero   <= '0;
		byte_one    <= '0;
		byte_two    <= '0;
		byte_three  <= '0;
		byte_four   <= '0;
		byte_five   <= '0;
		byte_six    <= '0;
		motor_index <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= mfdu_pkg::CFG_JUMP_THRESHOLD;
		cfg_data    <= '0;
		mismatch_count = 0;
		send_idle_pct  = 36;
		recv_idle_pct  = 79;
		jump_limit     = mfdu_pkg::RST_JUMP_THRESHOLD;
		center_ref     = mfdu_pkg::RST_CENTER_OFFSET;
		counts_turn    = mfdu_pkg::RST_COUNTS_PER_TURN;
		for (int k = 0; k < 8; k++) begin
			slot_angle[k] = '0;
			last_angle[k] = '0;
			turn_tally[k] = '0;
		end
		for (int k = 0; k < 6; k++)
			walk_angle[k] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < 25; r++) begin
			row = directed_rows[r];
			send_item(row.item, row.typed, '{row.known, row.grp, row.slot, 17'sd0, 32'sd0, 48'sd0});
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				in_valid <= 1'b0;
				wait_for_drain();
				case (p)
					1: regs = '{16'hffff, 16'h8000, 16'hffff};
					2: regs = '{16'h0000, 16'h7fff, 16'h0000};
					3: regs = '{16'h0001, 16'h0001, 16'h0001};
					5: regs = '{mfdu_pkg::RST_JUMP_THRESHOLD, 16'($urandom),
						mfdu_pkg::RST_COUNTS_PER_TURN};
					default: regs = '{16'($urandom_range(12000)), 16'($urandom), 16'($urandom)};
				endcase
				write_registers(regs);
			end
			mode = p * 3 / PHASES;
			case (mode)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 79;
				end
				1: begin
					send_idle_pct = 79;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_item(random_item(), 1'b0, '0);
		end

		in_valid <= 1'b0;
		wait_for_drain();
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#1000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
